### sv/sender_window_congestion_control_core_defines.svh
// assertion macros shared by the sender window controller rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef SENDER_WINDOW_CONGESTION_CONTROL_CORE_DEFINES_SVH
`define SENDER_WINDOW_CONGESTION_CONTROL_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SWCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SWCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/swcc_pkg.sv
// types and constants of the sender window controller
// no dependencies
`default_nettype none

package swcc_pkg;

    localparam logic [12:0] RST_INCREMENT   = 13'd1024;
    localparam logic [15:0] RST_THRESHOLD   = 16'd30720;
    localparam logic [12:0] RST_SPAN        = 13'd1032;
    localparam logic [14:0] RST_PEER_WINDOW = 15'd1024;
    localparam logic [31:0] RST_CWND        = 32'h0400_0000;
    localparam logic [31:0] WIN_MAX         = 32'hFFFF_0000;

    // quotient bits of increment << 16
    localparam int DIV_BITS  = 29;
    localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

    typedef enum logic [1:0] {
        MODE_ACK     = 2'd0,
        MODE_TIMEOUT = 2'd1,
        MODE_SEND    = 2'd2,
        MODE_START   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_WINDOW_INCREMENT  = 2'd0,
        CFG_INITIAL_THRESHOLD = 2'd1,
        CFG_PACKET_SPAN       = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACK_CHECK,
        ST_ACK_CMP,
        ST_ACK_DONE,
        ST_DIV,
        ST_TIMEOUT,
        ST_SEG_STEP,
        ST_SEG_PUSH,
        ST_START,
        ST_USE,
        ST_OUT
    } ctl_state_t;

    typedef struct packed {
        logic [31:0] ack_number;
        logic [14:0] peer_window;
        logic [12:0] segment_length;
        logic [14:0] initial_seq;
    } item_t;

    typedef struct packed {
        logic load;
        logic rd_head;
        logic pop;
        logic set_acc;
        logic ack_commit;
        logic cw_slow_add;
        logic div_start;
        logic cw_div_add;
        logic timeout;
        logic seg_step;
        logic seg_commit;
        logic conn_start;
        logic calc_usable;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic front_lt;
        logic front_eq;
        logic accepted;
        logic slow;
        logic armed;
        logic div_done;
    } ctl_stat_t;

    typedef struct packed {
        logic        queue_full;
        logic [15:0] slow_threshold;
        logic [15:0] usable_window;
        logic        can_send;
        logic        start_timer;
        logic        retransmit;
        logic [31:0] segment_seq;
        logic [31:0] base_seq;
        logic        accepted;
    } result_t;

endpackage

`default_nettype wire

### sv/sender_window_congestion_control_core.sv
// top level of the sender window controller: config registers, output register
// depends on swcc_pkg, swcc_ctrl, swcc_dp and the defines header
//
//   channel  | direction | beat contents
//   ---------+-----------+--------------------------------------------------
//   s_axis   | in        | tuser mode, tdata ack/peer window/length/initial seq
//   m_axis   | out       | tdata one result per input beat
//   cfg      | in        | cfg_index register, cfg_data value
//
// one item at a time, from the accepting edge to the result load: ack compares queue
// entries from the head (registered ram read) and pops matched or older ones, then
// grows the window, by an add in slow start or the one-bit-a-cycle divide in avoidance
// timeout, start, segment sent (step, push) update state, then usable window and load
// a new beat is taken while a result waits on m_axis; the block stalls at the
// end of the next item until that result is taken. no clearing pass after reset
`default_nettype none
`include "sender_window_congestion_control_core_defines.svh"

module sender_window_congestion_control_core #(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [74:60] initial_seq, [59:47] segment_length, [46:32] peer_window,
    // [31:0] ack_number, [79:75] zero
    input  wire logic [79:0]  s_tdata,
    // [1:0] mode
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [0] accepted, [32:1] base_seq, [64:33] segment_seq, [65] retransmit,
    // [66] start_timer, [67] can_send, [83:68] usable_window,
    // [99:84] slow_threshold, [100] queue_full, [103:101] zero
    output logic [103:0]      m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    import swcc_pkg::*;

    logic [12:0] incr_reg;
    logic [15:0] init_thr_reg;
    logic [12:0] span_reg;
    logic        m_tvalid_reg;
    logic [103:0] m_tdata_reg;

    ctl_cmd_t  cmd;
    ctl_stat_t stat;
    result_t   result;
    item_t     item;
    logic      out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            incr_reg     <= RST_INCREMENT;
            init_thr_reg <= RST_THRESHOLD;
            span_reg     <= RST_SPAN;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WINDOW_INCREMENT:  incr_reg     <= cfg_data[12:0];
                CFG_INITIAL_THRESHOLD: init_thr_reg <= cfg_data;
                CFG_PACKET_SPAN:       span_reg     <= cfg_data[12:0];
                default:               ;
            endcase
        end
    end

    assign item.ack_number     = s_tdata[31:0];
    assign item.peer_window    = s_tdata[46:32];
    assign item.segment_length = s_tdata[59:47];
    assign item.initial_seq    = s_tdata[74:60];

    assign out_free = !m_tvalid_reg || m_tready;

    swcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (mode_t'(s_tuser)),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    swcc_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .item              (item),
        .window_increment  (incr_reg),
        .initial_threshold (init_thr_reg),
        .packet_span       (span_reg),
        .stat              (stat),
        .result            (result)
    );

    // result register parts the output handshake from the controller
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= {3'b000, result};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SWCC_ASSERT_IMP(a_load_on_beat, s_tvalid && s_tready, cmd.load, "input beat not loaded")
    `SWCC_ASSERT_IMP(a_out_slot_free, cmd.out_load, !m_tvalid || m_tready, "result overwritten")
    `SWCC_ASSERT_IMP(a_commit_accepted, cmd.ack_commit, stat.accepted, "ack committed unmatched")
    `SWCC_ASSERT_IMP(a_div_avoid, cmd.div_start, !stat.slow, "divide started in slow start")
    `SWCC_ASSERT_NEXT(a_div_not_done, cmd.div_start, !stat.div_done, "divide done too early")

endmodule

`default_nettype wire

### sv/swcc_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module swcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### sv/swcc_ctrl.sv
// controller state machine of the sender window controller
// depends on swcc_pkg
`default_nettype none

module swcc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire swcc_pkg::mode_t      in_mode,
    input  wire logic                 out_free,
    input  wire swcc_pkg::ctl_stat_t  stat,
    output logic                      in_ready,
    output swcc_pkg::ctl_cmd_t        cmd
);

    import swcc_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (in_mode)
                        MODE_ACK:     state_next = ST_ACK_CHECK;
                        MODE_TIMEOUT: state_next = ST_TIMEOUT;
                        MODE_SEND:    state_next = ST_SEG_STEP;
                        MODE_START:   state_next = ST_START;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ACK_CHECK:
            begin
                if (stat.count_zero)
                begin
                    state_next = ST_ACK_DONE;
                end
                else
                begin
                    cmd.rd_head = 1'b1;
                    state_next  = ST_ACK_CMP;
                end
            end
            ST_ACK_CMP:
            begin
                // front entry is on the ram output now
                if (stat.front_lt)
                begin
                    state_next = ST_ACK_DONE;
                end
                else
                begin
                    cmd.pop = 1'b1;
                    if (stat.front_eq)
                    begin
                        cmd.set_acc = 1'b1;
                        state_next  = ST_ACK_DONE;
                    end
                    else
                    begin
                        state_next = ST_ACK_CHECK;
                    end
                end
            end
            ST_ACK_DONE:
            begin
                if (stat.accepted)
                begin
                    cmd.ack_commit = 1'b1;
                    if (stat.slow)
                    begin
                        cmd.cw_slow_add = 1'b1;
                        state_next      = ST_USE;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
                else
                begin
                    state_next = ST_USE;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.cw_div_add = 1'b1;
                    state_next     = ST_USE;
                end
            end
            ST_TIMEOUT:
            begin
                cmd.timeout = stat.armed;
                state_next  = ST_USE;
            end
            ST_SEG_STEP:
            begin
                cmd.seg_step = 1'b1;
                state_next   = ST_SEG_PUSH;
            end
            ST_SEG_PUSH:
            begin
                cmd.seg_commit = 1'b1;
                state_next     = ST_USE;
            end
            ST_START:
            begin
                cmd.conn_start = 1'b1;
                state_next     = ST_USE;
            end
            ST_USE:
            begin
                cmd.calc_usable = 1'b1;
                state_next      = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/swcc_dp.sv
// datapath of the sender window controller: queue, sequence state, window, divider
// depends on swcc_pkg and swcc_ram
`default_nettype none

module swcc_dp #(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire swcc_pkg::ctl_cmd_t  cmd,
    input  wire swcc_pkg::item_t     item,
    input  wire logic [12:0]         window_increment,
    input  wire logic [15:0]         initial_threshold,
    input  wire logic [12:0]         packet_span,
    output swcc_pkg::ctl_stat_t      stat,
    output swcc_pkg::result_t        result
);

    import swcc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = PTR_W + 2;

    // control state
    logic [PTR_W-1:0] head_reg;
    logic [CNT_W-1:0] count_reg;
    logic [31:0]      base_reg;
    logic [31:0]      next_seq_reg;
    logic [14:0]      peer_reg;
    logic [31:0]      cwnd_reg;
    logic [15:0]      thr_reg;
    logic             armed_reg;
    logic             acc_reg;
    logic             start_reg;
    logic             retx_reg;
    logic             full_reg;
    logic             div_busy_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // payload
    item_t            item_reg;
    logic [31:0]      seg_reg;
    logic [15:0]      usable_reg;
    logic [15:0]      div_rem_reg;
    logic [DIV_BITS-1:0] div_quo_reg;
    logic [15:0]      div_den_reg;

    // queue indexes, wrapped at the depth
    logic [SUM_W-1:0] push_sum;
    logic [SUM_W-1:0] tail_sum;
    logic [PTR_W-1:0] push_idx;
    logic [PTR_W-1:0] tail_idx;
    logic [PTR_W-1:0] head_inc;
    logic             q_full;

    assign push_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_sum = push_sum - SUM_W'(1);
    assign push_idx = (push_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      PTR_W'(push_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(push_sum);
    assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
    assign head_inc = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
    assign q_full   = (count_reg == CNT_W'(QUEUE_DEPTH));

    logic             count_zero;
    assign count_zero = (count_reg == '0);

    // ram ports
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [31:0]      wr_data;
    logic [31:0]      rd_data;
    logic             seg_newer;
    logic             seg_push;
    logic             ack_push;

    assign seg_newer = count_zero || (next_seq_reg > rd_data);
    assign seg_push  = cmd.seg_commit && seg_newer && !q_full;
    assign ack_push  = cmd.ack_commit && count_zero;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = push_idx;
        wr_data = next_seq_reg;
        if (cmd.conn_start)
        begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = 32'({1'b0, item_reg.initial_seq} + 16'd1);
        end
        else if (ack_push || seg_push)
        begin
            wr_en = 1'b1;
        end
    end

    swcc_ram #(
        .WIDTH (32),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_head || cmd.seg_step),
        .rd_addr (cmd.rd_head ? head_reg : tail_idx),
        .rd_data (rd_data)
    );

    // window arithmetic
    logic        slow;
    logic [15:0] cw_int;
    logic [15:0] div_den_start;
    logic [32:0] win_sum;
    logic [31:0] win_sat;
    logic [16:0] rem_shift;
    logic        rem_ge;
    logic [31:0] seg_end;

    assign slow          = cwnd_reg < {thr_reg, 16'h0000};
    assign cw_int        = cwnd_reg[31:16];
    assign div_den_start = (cw_int == '0) ? 16'd1 : cw_int;
    assign win_sum       = {1'b0, cwnd_reg} +
                           (cmd.cw_slow_add ? 33'({window_increment, 16'h0000})
                                            : 33'(div_quo_reg));
    assign win_sat       = (win_sum > 33'(WIN_MAX)) ? WIN_MAX : win_sum[31:0];
    assign rem_shift     = {div_rem_reg, div_quo_reg[DIV_BITS-1]};
    assign rem_ge        = rem_shift >= {1'b0, div_den_reg};
    assign seg_end       = next_seq_reg + 32'(item_reg.segment_length);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            base_reg     <= '0;
            next_seq_reg <= '0;
            peer_reg     <= RST_PEER_WINDOW;
            cwnd_reg     <= RST_CWND;
            thr_reg      <= RST_THRESHOLD;
            armed_reg    <= 1'b0;
            acc_reg      <= 1'b0;
            start_reg    <= 1'b0;
            retx_reg     <= 1'b0;
            full_reg     <= 1'b0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                acc_reg   <= 1'b0;
                start_reg <= 1'b0;
                retx_reg  <= 1'b0;
                full_reg  <= 1'b0;
            end
            if (cmd.pop)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.set_acc)
            begin
                acc_reg <= 1'b1;
            end
            if (cmd.ack_commit)
            begin
                peer_reg <= item_reg.peer_window;
                base_reg <= item_reg.ack_number;
                if (count_zero)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                begin
                    armed_reg <= 1'b1;
                    start_reg <= 1'b1;
                end
            end
            if (cmd.cw_slow_add || cmd.cw_div_add)
            begin
                cwnd_reg <= win_sat;
            end
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= DIV_CNT_W'(DIV_BITS);
            end
            else if (cmd.cw_div_add)
            begin
                div_busy_reg <= 1'b0;
            end
            else if (div_busy_reg && div_cnt_reg != '0)
            begin
                div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
            end
            if (cmd.timeout)
            begin
                next_seq_reg <= base_reg;
                if (slow)
                begin
                    thr_reg  <= 16'(cwnd_reg[31:17]);
                    cwnd_reg <= {3'b000, window_increment, 16'h0000};
                end
                else
                begin
                    cwnd_reg <= {1'b0, cwnd_reg[31:1]};
                end
            end
            if (cmd.seg_step)
            begin
                next_seq_reg <= seg_end;
                if (next_seq_reg == base_reg)
                begin
                    armed_reg <= 1'b1;
                    start_reg <= 1'b1;
                end
            end
            if (cmd.seg_commit)
            begin
                if (!seg_newer)
                begin
                    retx_reg <= 1'b1;
                end
                else if (q_full)
                begin
                    full_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.conn_start)
            begin
                head_reg     <= '0;
                count_reg    <= CNT_W'(1);
                next_seq_reg <= 32'({1'b0, item_reg.initial_seq} + 16'd1);
                cwnd_reg     <= {3'b000, window_increment, 16'h0000};
                thr_reg      <= initial_threshold;
                armed_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            seg_reg  <= '0;
        end
        if (cmd.seg_step)
        begin
            seg_reg <= next_seq_reg;
        end
        if (cmd.calc_usable)
        begin
            usable_reg <= (16'(peer_reg) < cw_int) ? 16'(peer_reg) : cw_int;
        end
        // restoring divide, one quotient bit a cycle
        if (cmd.div_start)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= {window_increment, 16'h0000};
            div_den_reg <= div_den_start;
        end
        else if (div_busy_reg && div_cnt_reg != '0)
        begin
            div_rem_reg <= rem_ge ? 16'(rem_shift - {1'b0, div_den_reg}) : rem_shift[15:0];
            div_quo_reg <= {div_quo_reg[DIV_BITS-2:0], rem_ge};
        end
    end

    assign stat.count_zero = count_zero;
    assign stat.front_lt   = item_reg.ack_number < rd_data;
    assign stat.front_eq   = item_reg.ack_number == rd_data;
    assign stat.accepted   = acc_reg;
    assign stat.slow       = slow;
    assign stat.armed      = armed_reg;
    assign stat.div_done   = div_busy_reg && (div_cnt_reg == '0);

    assign result.queue_full     = full_reg;
    assign result.slow_threshold = thr_reg;
    assign result.usable_window  = usable_reg;
    assign result.can_send       = ({1'b0, next_seq_reg} + 33'(packet_span)) <
                                   ({1'b0, base_reg} + 33'(usable_reg));
    assign result.start_timer    = start_reg;
    assign result.retransmit     = retx_reg;
    assign result.segment_seq    = seg_reg;
    assign result.base_seq       = base_reg;
    assign result.accepted       = acc_reg;

endmodule

`default_nettype wire
